FILE: rtl/dsdm_pkg.sv
// Shared constants, types and helper functions for the swerve drive mixer.
`default_nettype none

package dsdm_pkg;

  // Block constants
  localparam int COUNTS_PER_TURN = 4160;
  localparam int MAX_DRIVE       = 127;
  localparam int FRACTION_BITS   = 15;

  // Port widths
  localparam int CNT_W   = 13;
  localparam int POWER_W = 16;
  localparam int DRIVE_W = 8;

  // Trig formats
  localparam int TRIG_BITS  = 15;
  localparam int PHASE_BITS = 20;
  localparam int QUAD_BITS  = 18;
  localparam int POLY_FRAC  = 30;
  localparam int X_W        = QUAD_BITS + 1;
  localparam int S_W        = 31;
  localparam int MAG_W      = TRIG_BITS + 1;
  localparam int PMAG_W     = POWER_W;
  localparam int PROD_W     = MAG_W + PMAG_W;
  localparam int MIX_W      = PROD_W + 1;
  localparam int SCALE_SHIFT = TRIG_BITS + FRACTION_BITS;
  localparam int DRV_BITS   = $clog2(MAX_DRIVE + 1);
  localparam int SC_W       = MIX_W + DRV_BITS;

  // Phase = floor(|diff| * 2^PHASE_BITS / COUNTS_PER_TURN) by reciprocal and one correction
  localparam longint unsigned RECIP = (64'd1 << (PHASE_BITS + CNT_W)) / COUNTS_PER_TURN;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int QEST_W  = PHASE_BITS + 1;
  localparam int PROD1_W = (RECIP_W > QEST_W) ? CNT_W + RECIP_W : CNT_W + QEST_W;
  localparam int REM_W   = CNT_W + PHASE_BITS + 1;

  localparam logic [PHASE_BITS-1:0] QUARTER_PH = PHASE_BITS'(1) << QUAD_BITS;
  localparam logic [X_W-1:0]        QUARTER_X  = X_W'(1) << QUAD_BITS;

  // Horner coefficients of sin(pi/2 * x), Q30
  localparam int N_CELLS = 4;
  localparam logic [S_W-1:0] S_INIT = S_W'(172272);
  localparam logic [S_W-1:0] COEF [N_CELLS] = '{
    S_W'(5026995), S_W'(85569306), S_W'(693598668), S_W'(1686629713)
  };
  localparam logic [MAG_W-1:0] FULL_TRIG = MAG_W'(1) << TRIG_BITS;

  typedef struct packed {
    logic              cw;
    logic              xpos;
    logic [PMAG_W-1:0] pmag;
  } side_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [X_W-1:0] x2;
    logic [S_W-1:0] s;
  } lane_t;

  typedef struct packed {
    side_t side;
    lane_t sn;
    lane_t cs;
  } cell_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (32'(v) > 32'(COUNTS_PER_TURN)) r = CNT_W'(COUNTS_PER_TURN);
    return r;
  endfunction

  // Fold a phase into the first quadrant
  function automatic logic [X_W-1:0] fold(input logic [PHASE_BITS-1:0] ph);
    logic [X_W-1:0] off;
    off = {1'b0, ph[QUAD_BITS-1:0]};
    if (ph[QUAD_BITS]) off = QUARTER_X - off;
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/differential_swerve_drive_mixer.sv
// Top level of the differential swerve drive mixer: front pipeline, Horner cells, back end.
//
// Usage: present encoder_pulse_i (current wheel angle, counts), target_angle_i
// (counts, 4160 per turn) and power_i (signed Q1.15) with in_valid_i; a request
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// One result pair drive_a_o / drive_b_o (signed, -127..127) comes back per
// request on out_valid_o and is taken when out_stall_i is low.
// The pipeline has 14 register stages: 5 front (clamp and direction,
// reciprocal multiply, remainder correction, quadrant fold, square), 4
// Horner cells, 5 back (final product, rounding, power multiply, mix,
// saturation into the output register).
// Throughput is one request per cycle while the output is not stalled;
// each stage holds one request and moves it on whenever the next stage
// is empty or moving.
// A stalled output holds its pair; upstream stages keep taking requests
// until every stage is full, and only then is in_stall_o raised.
// Reset clears all valid bits; the block takes requests from the first
// cycle after reset.
`default_nettype none

module differential_swerve_drive_mixer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic        [dsdm_pkg::CNT_W-1:0]   encoder_pulse_i,
  input  wire logic        [dsdm_pkg::CNT_W-1:0]   target_angle_i,
  input  wire logic signed [dsdm_pkg::POWER_W-1:0] power_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dsdm_pkg::DRIVE_W-1:0]      drive_a_o,
  output logic signed [dsdm_pkg::DRIVE_W-1:0]      drive_b_o
);

  dsdm_pkg::cell_t               chain_data [dsdm_pkg::N_CELLS+1];
  logic [dsdm_pkg::N_CELLS:0]    chain_v;
  logic [dsdm_pkg::N_CELLS:0]    chain_en;
  logic                          front_en;

  assign in_stall_o = !front_en;

  dsdm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .encoder_pulse_i (encoder_pulse_i),
    .target_angle_i  (target_angle_i),
    .power_i         (power_i),
    .up_en_o         (front_en),
    .valid_o         (chain_v[0]),
    .data_o          (chain_data[0]),
    .down_en_i       (chain_en[0])
  );

  for (genvar i = 0; i < dsdm_pkg::N_CELLS; i++) begin : g_cell
    dsdm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .coef_i    (dsdm_pkg::COEF[i]),
      .valid_i   (chain_v[i]),
      .data_i    (chain_data[i]),
      .up_en_o   (chain_en[i]),
      .valid_o   (chain_v[i+1]),
      .data_o    (chain_data[i+1]),
      .down_en_i (chain_en[i+1])
    );
  end

  dsdm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (chain_v[dsdm_pkg::N_CELLS]),
    .data_i    (chain_data[dsdm_pkg::N_CELLS]),
    .up_en_o   (chain_en[dsdm_pkg::N_CELLS]),
    .valid_o   (out_valid_o),
    .drive_a_o (drive_a_o),
    .drive_b_o (drive_b_o),
    .down_en_i (!out_stall_i)
  );

  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_a_o != 8'sh80 && drive_b_o != 8'sh80)
    else $error("drive command outside the saturated range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && chain_v == '1)
    else $error("input stalled while the pipeline had room");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_a_o) && $stable(drive_b_o))
    else $error("drive pair dropped or changed while stalled");

endmodule

`default_nettype wire

FILE: rtl/dsdm_front.sv
// Front pipeline: clamp, direction, phase by reciprocal, quadrant fold and square.
`default_nettype none

module dsdm_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic        [dsdm_pkg::CNT_W-1:0]   encoder_pulse_i,
  input  wire logic        [dsdm_pkg::CNT_W-1:0]   target_angle_i,
  input  wire logic signed [dsdm_pkg::POWER_W-1:0] power_i,
  output logic                                     up_en_o,
  output logic                                     valid_o,
  output dsdm_pkg::cell_t                          data_o,
  input  wire logic                                down_en_i
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  // stage 1
  logic [dsdm_pkg::CNT_W-1:0]          cur, tgt;
  logic signed [dsdm_pkg::CNT_W:0]     diff;
  logic signed [dsdm_pkg::CNT_W+2:0]   d4;
  int                                  d4i;
  dsdm_pkg::side_t                     side_d;
  logic [dsdm_pkg::CNT_W:0]            adiff_w;
  logic [dsdm_pkg::CNT_W-1:0]          adiff1_q;
  dsdm_pkg::side_t                     side1_q;

  // stage 2
  logic [dsdm_pkg::PROD1_W-1:0]        prod1;
  logic [dsdm_pkg::QEST_W-1:0]         qest2_q;
  logic [dsdm_pkg::CNT_W-1:0]          adiff2_q;
  dsdm_pkg::side_t                     side2_q;

  // stage 3
  logic [dsdm_pkg::REM_W-1:0]          num, sub, rem;
  logic [dsdm_pkg::QEST_W-1:0]         qinc;
  logic [dsdm_pkg::PHASE_BITS-1:0]     phase_d, phase3_q;
  dsdm_pkg::side_t                     side3_q;

  // stage 4
  logic [dsdm_pkg::X_W-1:0]            xs4_q, xc4_q;
  dsdm_pkg::side_t                     side4_q;

  // stage 5
  logic [2*dsdm_pkg::X_W-1:0]          sq_s, sq_c;
  dsdm_pkg::cell_t                     data_d, data_q;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || down_en_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign up_en_o = en[0];
  assign valid_o = v_q[NSTG-1];
  assign data_o  = data_q;

  always_comb begin
    cur  = dsdm_pkg::clamp_count(encoder_pulse_i);
    tgt  = dsdm_pkg::clamp_count(target_angle_i);
    diff = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    d4   = (dsdm_pkg::CNT_W+3)'(diff) <<< 2;
    d4i  = int'(d4);
    if (!diff[dsdm_pkg::CNT_W]) begin
      side_d.cw = (d4i < 2 * dsdm_pkg::COUNTS_PER_TURN) ?
                  (d4i > dsdm_pkg::COUNTS_PER_TURN) :
                  (d4i > 3 * dsdm_pkg::COUNTS_PER_TURN);
    end else begin
      side_d.cw = (d4i > -2 * dsdm_pkg::COUNTS_PER_TURN) ?
                  (d4i > -dsdm_pkg::COUNTS_PER_TURN) :
                  (d4i > -3 * dsdm_pkg::COUNTS_PER_TURN);
    end
    side_d.xpos = ((int'({1'b0, tgt}) * 2 < dsdm_pkg::COUNTS_PER_TURN) ==
                   (int'({1'b0, cur}) * 2 <= dsdm_pkg::COUNTS_PER_TURN));
    side_d.pmag = power_i[dsdm_pkg::POWER_W-1] ? dsdm_pkg::PMAG_W'(-power_i) :
                                                 dsdm_pkg::PMAG_W'(power_i);
    adiff_w = diff[dsdm_pkg::CNT_W] ? (dsdm_pkg::CNT_W+1)'(-diff) :
                                      (dsdm_pkg::CNT_W+1)'(diff);
  end

  assign prod1 = dsdm_pkg::PROD1_W'(adiff1_q) * dsdm_pkg::PROD1_W'(dsdm_pkg::RECIP);

  // correct the reciprocal estimate by at most one
  always_comb begin
    num     = {1'b0, adiff2_q, dsdm_pkg::PHASE_BITS'(0)};
    sub     = dsdm_pkg::REM_W'(qest2_q) * dsdm_pkg::REM_W'(dsdm_pkg::COUNTS_PER_TURN);
    rem     = num - sub;
    qinc    = qest2_q + dsdm_pkg::QEST_W'(1);
    phase_d = (rem >= dsdm_pkg::REM_W'(dsdm_pkg::COUNTS_PER_TURN)) ?
              qinc[dsdm_pkg::PHASE_BITS-1:0] : qest2_q[dsdm_pkg::PHASE_BITS-1:0];
  end

  always_comb begin
    sq_s = (2*dsdm_pkg::X_W)'(xs4_q) * (2*dsdm_pkg::X_W)'(xs4_q);
    sq_c = (2*dsdm_pkg::X_W)'(xc4_q) * (2*dsdm_pkg::X_W)'(xc4_q);
    data_d.side  = side4_q;
    data_d.sn.x  = xs4_q;
    data_d.sn.x2 = sq_s[dsdm_pkg::QUAD_BITS +: dsdm_pkg::X_W];
    data_d.sn.s  = dsdm_pkg::S_INIT;
    data_d.cs.x  = xc4_q;
    data_d.cs.x2 = sq_c[dsdm_pkg::QUAD_BITS +: dsdm_pkg::X_W];
    data_d.cs.s  = dsdm_pkg::S_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      adiff1_q <= adiff_w[dsdm_pkg::CNT_W-1:0];
      side1_q  <= side_d;
    end
    if (en[1]) begin
      qest2_q  <= prod1[dsdm_pkg::CNT_W +: dsdm_pkg::QEST_W];
      adiff2_q <= adiff1_q;
      side2_q  <= side1_q;
    end
    if (en[2]) begin
      phase3_q <= phase_d;
      side3_q  <= side2_q;
    end
    if (en[3]) begin
      xs4_q   <= dsdm_pkg::fold(phase3_q);
      xc4_q   <= dsdm_pkg::fold(phase3_q + dsdm_pkg::QUARTER_PH);
      side4_q <= side3_q;
    end
    if (en[4]) begin
      data_q <= data_d;
    end
  end

  a_recip_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> rem < dsdm_pkg::REM_W'(2 * dsdm_pkg::COUNTS_PER_TURN))
    else $error("reciprocal estimate off by more than one");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> xs4_q <= dsdm_pkg::QUARTER_X && xc4_q <= dsdm_pkg::QUARTER_X)
    else $error("folded offset beyond a quarter turn");

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !up_en_o |-> v_q == '1 && !down_en_i)
    else $error("front stalled with a bubble inside");

endmodule

`default_nettype wire

FILE: rtl/dsdm_cell.sv
// One Horner step cell: s = coef - ((s * x^2) >> 18) for the sine and cosine lanes.
`default_nettype none

module dsdm_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [dsdm_pkg::S_W-1:0]   coef_i,
  input  wire logic                       valid_i,
  input  wire dsdm_pkg::cell_t            data_i,
  output logic                            up_en_o,
  output logic                            valid_o,
  output dsdm_pkg::cell_t                 data_o,
  input  wire logic                       down_en_i
);

  localparam int P_W = dsdm_pkg::S_W + dsdm_pkg::X_W;

  logic            en;
  logic            valid_q;
  logic [P_W-1:0]  prod_s, prod_c;
  dsdm_pkg::cell_t data_d, data_q;

  assign en      = !valid_q || down_en_i;
  assign up_en_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    prod_s = P_W'(data_i.sn.s) * P_W'(data_i.sn.x2);
    prod_c = P_W'(data_i.cs.s) * P_W'(data_i.cs.x2);
    data_d      = data_i;
    data_d.sn.s = coef_i - prod_s[dsdm_pkg::QUAD_BITS +: dsdm_pkg::S_W];
    data_d.cs.s = coef_i - prod_c[dsdm_pkg::QUAD_BITS +: dsdm_pkg::S_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) data_q <= data_d;
  end

  a_partial_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.sn.s <= coef_i && data_q.cs.s <= coef_i)
    else $error("Horner partial sum wrapped below zero");

  a_x2_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.sn.x2 <= data_q.sn.x && data_q.cs.x2 <= data_q.cs.x)
    else $error("square exceeds its operand");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !down_en_i |=> valid_q && $stable(data_q))
    else $error("cell lost its request while blocked");

endmodule

`default_nettype wire

FILE: rtl/dsdm_back.sv
// Back pipeline: final Horner product, rounding, power scaling, mix and drive saturation.
`default_nettype none

module dsdm_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire dsdm_pkg::cell_t                     data_i,
  output logic                                     up_en_o,
  output logic                                     valid_o,
  output logic signed [dsdm_pkg::DRIVE_W-1:0]      drive_a_o,
  output logic signed [dsdm_pkg::DRIVE_W-1:0]      drive_b_o,
  input  wire logic                                down_en_i
);

  localparam int NSTG = 5;
  localparam int P_W  = dsdm_pkg::S_W + dsdm_pkg::X_W;
  localparam int R_SH = dsdm_pkg::POLY_FRAC - dsdm_pkg::TRIG_BITS;

  function automatic logic [dsdm_pkg::MAG_W-1:0] round_q15(
    input logic [dsdm_pkg::S_W-1:0] s
  );
    logic [dsdm_pkg::S_W:0] sum;
    logic [dsdm_pkg::S_W:0] q;
    sum = {1'b0, s} + ((dsdm_pkg::S_W+1)'(1) << (R_SH - 1));
    q   = sum >> R_SH;
    if (q > (dsdm_pkg::S_W+1)'(dsdm_pkg::FULL_TRIG)) q = (dsdm_pkg::S_W+1)'(dsdm_pkg::FULL_TRIG);
    return q[dsdm_pkg::MAG_W-1:0];
  endfunction

  // truncate toward zero, saturate, negate, keep the low drive bits
  function automatic logic [dsdm_pkg::DRIVE_W-1:0] drive_out(
    input logic signed [dsdm_pkg::MIX_W-1:0] mix
  );
    logic                         neg;
    logic [dsdm_pkg::MIX_W-1:0]   mag;
    logic [dsdm_pkg::SC_W-1:0]    sc;
    neg = mix[dsdm_pkg::MIX_W-1];
    mag = neg ? dsdm_pkg::MIX_W'(-mix) : dsdm_pkg::MIX_W'(mix);
    sc  = (dsdm_pkg::SC_W'(mag) * dsdm_pkg::SC_W'(dsdm_pkg::MAX_DRIVE)) >> dsdm_pkg::SCALE_SHIFT;
    if (sc > dsdm_pkg::SC_W'(dsdm_pkg::MAX_DRIVE)) sc = dsdm_pkg::SC_W'(dsdm_pkg::MAX_DRIVE);
    return neg ? dsdm_pkg::DRIVE_W'(sc) : dsdm_pkg::DRIVE_W'(-sc);
  endfunction

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic [P_W-1:0]                          pf_s, pf_c;
  logic [dsdm_pkg::S_W-1:0]                sf_s1_q, sf_c1_q;
  dsdm_pkg::side_t                         side1_q, side2_q, side3_q;
  logic [dsdm_pkg::MAG_W-1:0]              q_s2_q, q_c2_q;
  logic [dsdm_pkg::PROD_W-1:0]             ymag3_q, xmag3_q;
  logic signed [dsdm_pkg::MIX_W-1:0]       y, x;
  logic signed [dsdm_pkg::MIX_W-1:0]       mix_a4_q, mix_b4_q;
  logic signed [dsdm_pkg::DRIVE_W-1:0]     drive_a_q, drive_b_q;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || down_en_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign up_en_o   = en[0];
  assign valid_o   = v_q[NSTG-1];
  assign drive_a_o = drive_a_q;
  assign drive_b_o = drive_b_q;

  assign pf_s = P_W'(data_i.sn.s) * P_W'(data_i.sn.x);
  assign pf_c = P_W'(data_i.cs.s) * P_W'(data_i.cs.x);

  always_comb begin
    y = side3_q.cw   ? $signed({1'b0, ymag3_q}) : -$signed({1'b0, ymag3_q});
    x = side3_q.xpos ? $signed({1'b0, xmag3_q}) : -$signed({1'b0, xmag3_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sf_s1_q <= pf_s[dsdm_pkg::QUAD_BITS +: dsdm_pkg::S_W];
      sf_c1_q <= pf_c[dsdm_pkg::QUAD_BITS +: dsdm_pkg::S_W];
      side1_q <= data_i.side;
    end
    if (en[1]) begin
      q_s2_q  <= round_q15(sf_s1_q);
      q_c2_q  <= round_q15(sf_c1_q);
      side2_q <= side1_q;
    end
    if (en[2]) begin
      ymag3_q <= dsdm_pkg::PROD_W'(q_s2_q) * dsdm_pkg::PROD_W'(side2_q.pmag);
      xmag3_q <= dsdm_pkg::PROD_W'(q_c2_q) * dsdm_pkg::PROD_W'(side2_q.pmag);
      side3_q <= side2_q;
    end
    if (en[3]) begin
      mix_a4_q <= y - x;
      mix_b4_q <= y + x;
    end
    if (en[4]) begin
      drive_a_q <= drive_out(mix_a4_q);
      drive_b_q <= drive_out(mix_b4_q);
    end
  end

  a_trig_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> q_s2_q <= dsdm_pkg::FULL_TRIG && q_c2_q <= dsdm_pkg::FULL_TRIG)
    else $error("rounded trig magnitude above one");

  // a + b is twice the angular term, so both mix terms share their low bit
  a_mix_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> mix_a4_q[0] == mix_b4_q[0])
    else $error("mix terms disagree with the angular magnitude");

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !up_en_o |-> v_q == '1 && !down_en_i)
    else $error("back end stalled with a bubble inside");

endmodule

`default_nettype wire
